>>> src/rmsn_pkg.sv
package rmsn_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 64;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned EPS_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned SCALE_W   = 37;
  localparam int unsigned DEN_W     = 37;
  localparam int unsigned ITER_W    = 74;
  localparam int unsigned REM_W     = 40;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned SPLIT_W   = 19;
  localparam int unsigned MUL_W     = PROD_W + SPLIT_W;
  localparam int unsigned WIDE_W    = 70;
  localparam int unsigned FRAC_SH   = 36;
  localparam int unsigned SAT_BIT   = 52;

  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(64);
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);

  localparam logic [STEP_W-1:0] STEPS_MEAN  = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] STEPS_RECIP = STEP_W'(ITER_W);
  localparam logic [STEP_W-1:0] STEPS_ROOT  = STEP_W'(ITER_W / 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH  = 1'b0,
    REG_EPSILON = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } iter_mode_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_RECIP,
    ST_ROOT,
    ST_RD,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    iter_mode_e        mode;
    logic [STEP_W-1:0] steps;
  } iter_cmd_t;

endpackage

>>> src/rms_normalize_vector.sv
// Channel  Direction  Handshake                Beat
// in       sink       in_valid_i / in_ready_o  x_value_i, weight_value_i
// out      source     out_valid_o / out_ready_i y_value_o, last_out_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Loading: one beat per cycle; a vector then passes through a mean divide, a
// reciprocal divide and a sqrt in the shared shift-subtract unit, then each
// result takes the steps RAM read, magnitude, two passes through the 32x19
// multiplier and round/saturate.
// Input is not ready from the end of a vector until its last result is
// registered. Output stalls hold the emission pass. cfg is always ready.
// Reset: length 64, epsilon 1, sums and counts cleared; store undefined.
module rms_normalize_vector
  import rmsn_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DATA_W-1:0]    x_value_i,
  input  logic signed [DATA_W-1:0]    weight_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_W-1:0]    y_value_o,
  output logic                        last_out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]            cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LENGTH);
  localparam int unsigned CW = $clog2(MAX_LENGTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0]      count_q, count_inc, idx_q, last_n_q;
  logic [SUM_W-1:0]   sum_q, sum_inc;
  logic [LEN_W-1:0]   len_q, eff_len;
  logic [EPS_W-1:0]   eps_q;
  logic [SCALE_W-1:0] scale_q;
  logic [PROD_W-1:0]  mag_q, mag_d;
  logic               neg_q;
  logic [MUL_W-1:0]   plo_q, phi_q, mul_res;
  logic [SPLIT_W-1:0] mul_b;
  logic               out_valid_q, last_q;
  logic [DATA_W-1:0]  y_q, y_d;

  logic signed [PROD_W-1:0] prod, sq;
  logic                     in_acc, vec_end, out_free, last_el;
  logic [DEN_W-1:0]         ms_raw, ms;
  logic [WIDE_W-1:0]        total;
  logic [SAT_BIT:0]         rounded;
  logic [DATA_W:0]          qmag;
  logic                     big;

  iter_cmd_t          cmd;
  logic [ITER_W-1:0]  iter_num, iter_res;
  logic [DEN_W-1:0]   iter_den;
  logic               iter_done;
  logic [PROD_W-1:0]  ram_rdata;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;

  assign prod      = x_value_i * weight_value_i;
  assign sq        = x_value_i * x_value_i;
  assign sum_inc   = sum_q + SUM_W'($unsigned(sq));
  assign count_inc = count_q + CW'(1);

  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_LENGTH)) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = len_q;
    end
  end

  assign vec_end  = LEN_W'(count_inc) >= eff_len;
  assign ms_raw   = DEN_W'(iter_res[SUM_W-1:0]) + DEN_W'(eps_q);
  assign ms       = (ms_raw == '0) ? DEN_W'(1) : ms_raw;
  assign out_free = ~out_valid_q | out_ready_i;
  assign last_el  = (idx_q == last_n_q - CW'(1));

  // scaling datapath
  assign mag_d   = ram_rdata[PROD_W-1] ? (~ram_rdata + PROD_W'(1)) : ram_rdata;
  assign mul_b   = (state_q == ST_MUL_LO) ? scale_q[SPLIT_W-1:0]
                                          : SPLIT_W'(scale_q[SCALE_W-1:SPLIT_W]);
  assign mul_res = MUL_W'(mag_q) * MUL_W'(mul_b);
  assign total   = WIDE_W'(plo_q) + (WIDE_W'(phi_q) << SPLIT_W);
  assign big     = |total[WIDE_W-1:SAT_BIT];
  assign rounded = (SAT_BIT+1)'(total[SAT_BIT-1:0]) + ((SAT_BIT+1)'(1) << (FRAC_SH - 1));
  assign qmag    = rounded[SAT_BIT:FRAC_SH];

  always_comb begin
    if (neg_q) begin
      if (big || qmag > (DATA_W+1)'(32768)) begin
        y_d = 16'h8000;
      end else begin
        y_d = DATA_W'(~qmag + (DATA_W+1)'(1));
      end
    end else begin
      if (big || qmag > (DATA_W+1)'(32767)) begin
        y_d = 16'h7fff;
      end else begin
        y_d = qmag[DATA_W-1:0];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd.start = 1'b0;
    cmd.mode  = MODE_DIV;
    cmd.steps = STEPS_MEAN;
    iter_num  = {sum_inc, (ITER_W-SUM_W)'(0)};
    iter_den  = DEN_W'(eff_len);
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && vec_end) begin
          cmd.start = 1'b1;
          state_d   = ST_MEAN;
        end
      end
      ST_MEAN: begin
        iter_num  = ITER_W'(1) << (2 * FRAC_SH);
        iter_den  = ms;
        cmd.steps = STEPS_RECIP;
        if (iter_done) begin
          cmd.start = 1'b1;
          state_d   = ST_RECIP;
        end
      end
      ST_RECIP: begin
        iter_num  = {1'b0, iter_res[ITER_W-2:0]};
        cmd.mode  = MODE_SQRT;
        cmd.steps = STEPS_ROOT;
        if (iter_done) begin
          cmd.start = 1'b1;
          state_d   = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (iter_done) begin
          state_d = ST_RD;
        end
      end
      ST_RD:     state_d = ST_ABS;
      ST_ABS:    state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = last_el ? ST_LOAD : ST_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      len_q       <= LEN_RST;
      eps_q       <= EPS_RST;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      last_n_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_LENGTH:  len_q <= cfg_data_i[LEN_W-1:0];
          REG_EPSILON: eps_q <= cfg_data_i[EPS_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (vec_end) begin
          count_q  <= '0;
          sum_q    <= '0;
          last_n_q <= count_inc;
          idx_q    <= '0;
        end else begin
          count_q <= count_inc;
          sum_q   <= sum_inc;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + CW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROOT && iter_done) begin
      scale_q <= iter_res[SCALE_W-1:0];
    end
    if (state_q == ST_ABS) begin
      mag_q <= mag_d;
      neg_q <= ram_rdata[PROD_W-1];
    end
    if (state_q == ST_MUL_LO) begin
      plo_q <= mul_res;
    end
    if (state_q == ST_MUL_HI) begin
      phi_q <= mul_res;
    end
    if (state_q == ST_OUT && out_free) begin
      y_q    <= y_d;
      last_q <= last_el;
    end
  end

  rmsn_ram #(
    .WIDTH (PROD_W),
    .DEPTH (MAX_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (prod),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  rmsn_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .num_i  (iter_num),
    .den_i  (iter_den),
    .done_o (iter_done),
    .res_o  (iter_res)
  );

  assign out_valid_o = out_valid_q;
  assign y_value_o   = y_q;
  assign last_out_o  = last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CW'(MAX_LENGTH))
    else $error("element count reached store depth");

  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_done |-> (state_q == ST_MEAN || state_q == ST_RECIP || state_q == ST_ROOT))
    else $error("iterative unit finished outside a compute state");

  a_scale_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |-> scale_q != '0)
    else $error("zero scale");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free && last_el) |=>
      (state_q == ST_LOAD && out_valid_q && last_q))
    else $error("final beat did not close the vector");

endmodule

>>> src/rmsn_ram.sv
module rmsn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rmsn_iter_unit.sv
// shift-subtract unit: restoring divide (1 bit/cycle) or integer sqrt (2 bits/cycle)
module rmsn_iter_unit
  import rmsn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iter_cmd_t         cmd_i,
  input  logic [ITER_W-1:0] num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [ITER_W-1:0] res_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [ITER_W-1:0] n_q, q_q;
  logic [REM_W-1:0]  r_q;
  logic [DEN_W-1:0]  den_q;
  iter_mode_e        mode_q;

  logic [REM_W-1:0] shifted, sub;
  logic [REM_W:0]   diff;
  logic             ge;

  always_comb begin
    if (mode_q == MODE_SQRT) begin
      shifted = {r_q[REM_W-3:0], n_q[ITER_W-1 -: 2]};
      sub     = REM_W'({q_q[SCALE_W-1:0], 2'b01});
    end else begin
      shifted = {r_q[REM_W-2:0], n_q[ITER_W-1]};
      sub     = REM_W'(den_q);
    end
    diff = {1'b0, shifted} - {1'b0, sub};
    ge   = ~diff[REM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q    <= num_i;
      r_q    <= '0;
      q_q    <= '0;
      den_q  <= den_i;
      mode_q <= cmd_i.mode;
    end else if (busy_q) begin
      n_q <= (mode_q == MODE_SQRT) ? (n_q << 2) : (n_q << 1);
      r_q <= ge ? diff[REM_W-1:0] : shifted;
      q_q <= {q_q[ITER_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = q_q;

endmodule
